@@ rtl/round_robin_thread_slot_scheduler_top_macros.svh @@
// Assertion macros for the thread slot scheduler checker.
// Included by the checker file; no other dependencies.
`ifndef ROUND_ROBIN_THREAD_SLOT_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_THREAD_SLOT_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("thread scheduler check failed");

// Next-cycle implication, disabled during reset.
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("thread scheduler check failed");

`endif

@@ rtl/rrts_pkg.sv @@
// Package for the round-robin thread slot scheduler: field layout,
// function codes and sequencer states. No dependencies.
package rrts_pkg;

   localparam int NumSlotsDefault = 4;

   // Request fields
   localparam int FuncW     = 2;
   localparam int StackW    = 16;
   localparam int QueryW    = 4;
   localparam int StackLsb  = 0;
   localparam int QueryLsb  = 16;
   localparam int ReqDataW  = 24;

   // Response fields
   localparam int RunW       = 3;
   localparam int NewW       = 3;
   localparam int RunLsb     = 0;
   localparam int RestoreLsb = 3;
   localparam int NewLsb     = 19;
   localparam int OkBit      = 22;
   localparam int StatusBit  = 23;
   localparam int RspDataW   = 24;

   typedef enum logic [FuncW-1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_CREATE = 2'd1,
      FUNC_EXIT   = 2'd2,
      FUNC_QUERY  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAVE,
      ST_SCAN,
      ST_FREE,
      ST_READ,
      ST_DONE
   } sched_state_type;

endpackage

@@ rtl/rrts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 5
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/round_robin_thread_slot_scheduler_top.sv @@
// Top level of the round-robin thread slot scheduler: sequencer, active
// bits and the shared slot probe. Uses rrts_pkg and rrts_ram.
//
//  Channel | Dir | Handshake             | Payload
//  --------+-----+-----------------------+-----------------------------------
//  req     | in  | req_tvalid/req_tready | tuser: func; tdata: stack, query id
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: run id, restore sp, new id,
//          |     |                       |        ok flag, status flag
//
// One transaction at a time. A single probe unit (compare against the last
// slot, active-bit lookup, increment) tests one thread id per cycle.
// Tick / exit: the save write, then a probe of each id above the running thread
// until a hit or the probe runs past the last slot, then the RAM's registered
// read. Create: probes slots from slot 1 until a free one or past the last
// slot. Query and exit from main go straight to the response. A stalled
// response holds in the output register; the sequencer waits in its last state
// until that register frees up. Reset clears the active bits and makes main the
// running thread; the stack RAM is not cleared (each entry is written before it is read).
module round_robin_thread_slot_scheduler_top
   import rrts_pkg::*;
#(
   parameter int NUM_SLOTS = NumSlotsDefault
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // [15:0] stack_value, [19:16] query_thread
   input  logic [FuncW-1:0]    req_tuser,   // [1:0] func

   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata    // [2:0] running_thread, [18:3] restore_stack,
                                            // [21:19] new_thread, [22] done_ok,
                                            // [23] slot_status
);

   // Thread ids run 0 (main) .. NUM_SLOTS; the probe must also hold NUM_SLOTS+1.
   localparam int IdW     = $clog2(NUM_SLOTS + 1);
   localparam int ProbeW  = $clog2(NUM_SLOTS + 2);
   localparam int IdDepth = 2 ** IdW;
   localparam logic [ProbeW-1:0] LastProbe = ProbeW'(NUM_SLOTS);
   localparam logic [QueryW-1:0] LastQuery = QueryW'(NUM_SLOTS);

   sched_state_type       state_ff, state_in;
   logic [StackW-1:0]     sp_ff, sp_in;
   logic [IdW-1:0]        cur_ff, cur_in;
   logic [ProbeW-1:0]     probe_ff, probe_in;
   logic [NUM_SLOTS-1:0]  active_ff, active_in;      // bit i = thread i+1
   logic [StackW-1:0]     res_restore_ff, res_restore_in;
   logic [IdW-1:0]        res_new_ff, res_new_in;
   logic                  res_ok_ff, res_ok_in;
   logic                  res_status_ff, res_status_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RspDataW-1:0]   rsp_tdata_ff, rsp_tdata_in;

   // Active bits by thread id; main and ids past the last slot read 0.
   logic [IdDepth-1:0]    act_by_id;
   logic [IdDepth-1:0]    cur_onehot;
   logic [IdDepth-1:0]    probe_onehot;

   // Shared probe unit
   logic                  probe_over;
   logic                  probe_hit;
   logic [IdW-1:0]        probe_id;

   // Query decode straight off the request
   logic [QueryW-1:0]     req_query;
   logic                  query_hit;

   // RAM port
   logic                  ram_wr_en;
   logic [IdW-1:0]        ram_wr_addr;
   logic                  ram_rd_en;
   logic [IdW-1:0]        ram_rd_addr;
   logic [StackW-1:0]     ram_rd_data;

   logic                  req_fire;
   logic                  rsp_free;

   assign act_by_id    = IdDepth'({active_ff, 1'b0});
   assign probe_id     = probe_ff[IdW-1:0];
   assign cur_onehot   = IdDepth'(1) << cur_ff;
   assign probe_onehot = IdDepth'(1) << probe_id;

   assign probe_over = probe_ff > LastProbe;
   assign probe_hit  = !probe_over && act_by_id[probe_id];

   assign req_query = req_tdata[QueryLsb +: QueryW];
   assign query_hit = (req_query == '0) ||
                      ((req_query <= LastQuery) && act_by_id[req_query[IdW-1:0]]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   // Stack pointers: entry 0 is main, entry i is thread i.
   rrts_ram #(
      .WIDTH (StackW),
      .DEPTH (NUM_SLOTS + 1)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (sp_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Switch target: the hit slot, or main once the probe runs off the end.
   assign ram_rd_addr = probe_over ? '0 : probe_id;
   assign ram_rd_en   = (state_ff == ST_SCAN) && (probe_over || probe_hit);
   assign ram_wr_addr = (state_ff == ST_SAVE) ? cur_ff : probe_id;
   assign ram_wr_en   = (state_ff == ST_SAVE) ||
                        ((state_ff == ST_FREE) && !probe_over && !act_by_id[probe_id]);

   always_comb begin
      state_in       = state_ff;
      sp_in          = sp_ff;
      cur_in         = cur_ff;
      probe_in       = probe_ff;
      active_in      = active_ff;
      res_restore_in = res_restore_ff;
      res_new_in     = res_new_ff;
      res_ok_in      = res_ok_ff;
      res_status_in  = res_status_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in   = rsp_tdata_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sp_in          = req_tdata[StackLsb +: StackW];
               res_restore_in = '0;
               res_new_in     = '0;
               res_ok_in      = 1'b1;
               res_status_in  = 1'b0;
               probe_in       = ProbeW'(1);
               unique case (func_type'(req_tuser))
                  FUNC_TICK: begin
                     state_in = ST_SAVE;
                  end
                  FUNC_CREATE: begin
                     state_in = ST_FREE;
                  end
                  FUNC_EXIT: begin
                     if (cur_ff != '0) begin
                        active_in = active_ff & ~cur_onehot[NUM_SLOTS:1];
                        state_in  = ST_SAVE;
                     end else begin
                        state_in  = ST_DONE;
                     end
                  end
                  FUNC_QUERY: begin
                     res_status_in = query_hit;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end
         ST_SAVE: begin
            // RAM write of the running thread's sp happens this cycle
            probe_in = ProbeW'(cur_ff) + ProbeW'(1);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (probe_over) begin
               cur_in   = '0;
               state_in = ST_READ;
            end else if (probe_hit) begin
               cur_in   = probe_id;
               state_in = ST_READ;
            end else begin
               probe_in = probe_ff + ProbeW'(1);
            end
         end
         ST_FREE: begin
            if (probe_over) begin
               res_ok_in = 1'b0;
               state_in  = ST_DONE;
            end else if (!act_by_id[probe_id]) begin
               active_in  = active_ff | probe_onehot[NUM_SLOTS:1];
               res_new_in = probe_id;
               state_in   = ST_DONE;
            end else begin
               probe_in = probe_ff + ProbeW'(1);
            end
         end
         ST_READ: begin
            res_restore_in = ram_rd_data;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {res_status_ff, res_ok_ff, NewW'(res_new_ff),
                                res_restore_ff, RunW'(cur_ff)};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_ff        <= '0;
         active_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         active_ff     <= active_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff          <= sp_in;
      probe_ff       <= probe_in;
      res_restore_ff <= res_restore_in;
      res_new_ff     <= res_new_in;
      res_ok_ff      <= res_ok_in;
      res_status_ff  <= res_status_in;
      rsp_tdata_ff   <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

@@ rtl/rrts_checker.sv @@
// Port-level checker for the thread slot scheduler, bound to the top level.
// Uses rrts_pkg and round_robin_thread_slot_scheduler_top_macros.svh.
`include "round_robin_thread_slot_scheduler_top_macros.svh"

module rrts_checker
   import rrts_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [ReqDataW-1:0] req_tdata,
   input logic [FuncW-1:0]    req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata
);

   // A stalled response keeps its payload.
   `RRTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // One transaction in flight: the block is busy the cycle after accepting.
   `RRTS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // A failed create hands out no thread id.
   `RRTS_ASSERT_IMPLY(a_fail_no_id, clock, reset, rsp_tvalid && !rsp_tdata[OkBit], rsp_tdata[NewLsb +: NewW] == '0)

   // A status answer never comes with a new id or a restored stack.
   `RRTS_ASSERT_IMPLY(a_status_alone, clock, reset, rsp_tvalid && rsp_tdata[StatusBit], (rsp_tdata[NewLsb +: NewW] == '0) && (rsp_tdata[RestoreLsb +: StackW] == '0))

endmodule

bind round_robin_thread_slot_scheduler_top rrts_checker u_checker (.*);
